@@ rtl/ndwag_pkg.sv @@
// Shared constants for the N-dimensional window address generator.
package ndwag_pkg;

  // Widths fixed by the stream fields.
  localparam int IN_W      = 32;  // pattern_number and element_position
  localparam int IN_TD_W   = 64;  // input tdata width
  localparam int OUT_W     = 32;  // flat_address
  localparam int OUT_TD_W  = 40;  // output tdata width, rounded up to bytes
  localparam int CFG_IDX_W = 3;
  localparam int DUSED_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARRAY_SIZES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OFFSETS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_SIZES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNTS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MASK       = 3'd6;

endpackage

@@ rtl/ndwag_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
module ndwag_divider #(
  parameter int LANES  = 2,
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]       in_num,
  input  logic [LANES-1:0][DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic [LANES-1:0][NUM_W-1:0]       out_quo,
  output logic [LANES-1:0][DEN_W-1:0]       out_rem,
  output logic [SIDE_W-1:0]                 out_side
);

  logic [NUM_W-1:0]                   vld;
  logic [LANES-1:0][NUM_W-1:0]        num_r   [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]        rem_r   [NUM_W];
  logic [SIDE_W-1:0]                  side_r  [NUM_W];
  logic [LANES-1:0][NUM_W-1:0]        num_next[NUM_W];
  logic [LANES-1:0][DEN_W-1:0]        rem_next[NUM_W];
  logic [NUM_W-1:0]                   p_num;
  logic [DEN_W-1:0]                   p_rem;
  logic [DEN_W:0]                     trial;
  logic [DEN_W:0]                     diff;
  logic                               ge;

  // Each stage brings down one dividend bit and tries one subtraction.
  always_comb begin
    p_num = '0;
    p_rem = '0;
    trial = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int s = 0; s < NUM_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          p_num = in_num[l];
          p_rem = '0;
        end else begin
          p_num = num_r[s-1][l];
          p_rem = rem_r[s-1][l];
        end
        trial = {p_rem, p_num[NUM_W-1]};
        diff  = trial - {1'b0, den[l]};
        ge    = (trial >= {1'b0, den[l]});
        rem_next[s][l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next[s][l] = {p_num[NUM_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NUM_W; s++) begin
        num_r[s] <= num_next[s];
        rem_r[s] <= rem_next[s];
        if (s == 0) begin
          side_r[s] <= in_side;
        end else begin
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign out_quo   = num_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

@@ rtl/nd_window_address_generator_top.sv @@
// Top level of the N-dimensional window address generator.
//
// This block turns a (pattern number, element position) beat into the flat
// row-major address of one element of a stored array of up to NUM_DIMS
// dimensions, the way an im2col unit walks patches. Both input indices are
// split into mixed-radix digits, last dimension fastest; the coordinate of
// each dimension is offset plus step digit times stride plus window digit.
// Dimensions flagged in wrap_mask wrap by a non-negative modulo of the array
// size, the others report padding when they fall outside the array, and an
// element position beyond the window volume is reported as a bad element.
// The block takes one beat every clock while the output is not stalled, and
// returns one beat per input beat, in order. The pipeline depth is set by the
// bit-serial digit dividers, one chain of 32 stages per dimension, and by the
// modulo divider for wrapping coordinates.
// The whole pipeline advances when the output register is empty or being
// taken, so s_tready follows m_tready while a result is waiting.
// The user must write configuration only while no beat is in flight; the block
// itself does not enforce this. Derived scale factors settle through registers.
module nd_window_address_generator_top
  import ndwag_pkg::*;
#(
  parameter int NUM_DIMS  = 4,
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write port.
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [NUM_DIMS*DIM_BITS-1:0] cfg_wdata,
  // Input stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [IN_TD_W-1:0]           s_tdata,   // pattern_number, element_position
  // Output stream.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [OUT_TD_W-1:0]          m_tdata    // flat_address, is_padding, bad_element
);

  localparam int REG_W  = NUM_DIMS * DIM_BITS;
  localparam int CW     = 2 * DIM_BITS + 2;   // signed coordinate width
  localparam int MW     = CW - 1;             // coordinate magnitude width
  localparam int DSIDE  = 2 * NUM_DIMS * DIM_BITS;
  localparam int MSIDE  = 1 + 2 * NUM_DIMS + NUM_DIMS * DIM_BITS;

  // Configuration registers.
  logic [DUSED_W-1:0]  dims_used;
  logic [REG_W-1:0]    array_sizes;
  logic [REG_W-1:0]    window_sizes;
  logic [REG_W-1:0]    window_offsets;
  logic [REG_W-1:0]    stride_sizes;
  logic [REG_W-1:0]    position_counts;
  logic [NUM_DIMS-1:0] wrap_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_used       <= DUSED_W'(1);
      array_sizes     <= '0;
      window_sizes    <= '0;
      window_offsets  <= '0;
      stride_sizes    <= '0;
      position_counts <= '0;
      wrap_mask       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIMS_USED:       dims_used       <= cfg_wdata[DUSED_W-1:0];
        REG_ARRAY_SIZES:     array_sizes     <= cfg_wdata;
        REG_WINDOW_SIZES:    window_sizes    <= cfg_wdata;
        REG_WINDOW_OFFSETS:  window_offsets  <= cfg_wdata;
        REG_STRIDE_SIZES:    stride_sizes    <= cfg_wdata;
        REG_POSITION_COUNTS: position_counts <= cfg_wdata;
        REG_WRAP_MASK:       wrap_mask       <= cfg_wdata[NUM_DIMS-1:0];
        default: ;
      endcase
    end
  end

  // Per-dimension fields; dimension 0 sits in the top bits of each register.
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] sz, ws, off, stride, cnt, cnt_eff, ws_eff;
  logic [NUM_DIMS-1:0]               used;
  logic [NUM_DIMS-1:0]               ws_zero;
  logic [DUSED_W-1:0]                n_eff;
  logic                              ws_zero_any;

  always_comb begin
    if (dims_used == '0) begin
      n_eff = DUSED_W'(1);
    end else if (dims_used > DUSED_W'(NUM_DIMS)) begin
      n_eff = DUSED_W'(NUM_DIMS);
    end else begin
      n_eff = dims_used;
    end
  end

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_fields
    localparam int LSB = (NUM_DIMS - 1 - d) * DIM_BITS;
    assign sz[d]     = array_sizes[LSB +: DIM_BITS];
    assign ws[d]     = window_sizes[LSB +: DIM_BITS];
    assign off[d]    = window_offsets[LSB +: DIM_BITS];
    assign stride[d] = stride_sizes[LSB +: DIM_BITS];
    assign cnt[d]    = position_counts[LSB +: DIM_BITS];
    assign used[d]   = (DUSED_W'(d) < n_eff);
    // Unused dimensions divide by one so they leave both indices untouched.
    assign cnt_eff[d] = (!used[d] || cnt[d] == '0) ? DIM_BITS'(1) : cnt[d];
    assign ws_eff[d]  = used[d] ? ws[d] : DIM_BITS'(1);
    assign ws_zero[d] = used[d] && (ws[d] == '0);
  end
  assign ws_zero_any = |ws_zero;

  // Row-major scale of each dimension: product of the used sizes after it.
  logic [ADDR_BITS-1:0] mscale [NUM_DIMS];

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_scale
    if (d == NUM_DIMS - 1) begin : g_last
      always_ff @(posedge clk) begin
        mscale[d] <= ADDR_BITS'(1);
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (rst || !used[d+1]) begin
          mscale[d] <= ADDR_BITS'(1);
        end else begin
          mscale[d] <= mscale[d+1] * ADDR_BITS'(sz[d+1]);
        end
      end
    end
  end

  // The pipeline moves as one; the output register is the only place a
  // result can wait.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Digit extraction: one divider chain per dimension, last dimension first.
  // Lane 0 splits the pattern number, lane 1 the element position.
  logic                              dv_valid [NUM_DIMS+1];
  logic [IN_W-1:0]                   dv_pat   [NUM_DIMS+1];
  logic [IN_W-1:0]                   dv_elem  [NUM_DIMS+1];
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] dv_pd    [NUM_DIMS+1];
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] dv_ed    [NUM_DIMS+1];

  assign dv_valid[0] = s_tvalid;
  assign dv_pat[0]   = s_tdata[IN_W-1:0];
  assign dv_elem[0]  = s_tdata[2*IN_W-1:IN_W];
  assign dv_pd[0]    = '0;
  assign dv_ed[0]    = '0;

  for (genvar j = 0; j < NUM_DIMS; j++) begin : g_digit
    localparam int D = NUM_DIMS - 1 - j;
    logic [1:0][IN_W-1:0]              quo;
    logic [1:0][DIM_BITS-1:0]          rem;
    logic [DSIDE-1:0]                  side_o;
    logic [NUM_DIMS-1:0][DIM_BITS-1:0] pd_o, ed_o, pd_n, ed_n;

    ndwag_divider #(
      .LANES (2),
      .NUM_W (IN_W),
      .DEN_W (DIM_BITS),
      .SIDE_W(DSIDE)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (dv_valid[j]),
      .in_num   ({dv_elem[j], dv_pat[j]}),
      .den      ({ws_eff[D], cnt_eff[D]}),
      .in_side  ({dv_pd[j], dv_ed[j]}),
      .out_valid(dv_valid[j+1]),
      .out_quo  (quo),
      .out_rem  (rem),
      .out_side (side_o)
    );

    assign {pd_o, ed_o} = side_o;

    always_comb begin
      pd_n    = pd_o;
      ed_n    = ed_o;
      pd_n[D] = rem[0];
      ed_n[D] = rem[1];
    end

    assign dv_pat[j+1]  = quo[0];
    assign dv_elem[j+1] = quo[1];
    assign dv_pd[j+1]   = pd_n;
    assign dv_ed[j+1]   = ed_n;
  end

  // Stage C1: step digit times stride. Whatever of the element position is
  // left after all window digits means it lies beyond the window volume.
  logic                                c1_valid;
  logic                                c1_bad;
  logic [NUM_DIMS-1:0][2*DIM_BITS-1:0] c1_prod;
  logic [NUM_DIMS-1:0][DIM_BITS-1:0]   c1_ed;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (adv) begin
      c1_valid <= dv_valid[NUM_DIMS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_bad <= ws_zero_any || (dv_elem[NUM_DIMS] != '0);
      c1_ed  <= dv_ed[NUM_DIMS];
      for (int d = 0; d < NUM_DIMS; d++) begin
        c1_prod[d] <= (2*DIM_BITS)'(dv_pd[NUM_DIMS][d]) * (2*DIM_BITS)'(stride[d]);
      end
    end
  end

  // Stage C2: signed coordinate = offset + stride product + window digit.
  logic                        c2_valid;
  logic                        c2_bad;
  logic [NUM_DIMS-1:0][CW-1:0] c2_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
    end else if (adv) begin
      c2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_bad <= c1_bad;
      for (int d = 0; d < NUM_DIMS; d++) begin
        c2_c[d] <= {{(CW-DIM_BITS){off[d][DIM_BITS-1]}}, off[d]}
                 + {2'b00, c1_prod[d]}
                 + CW'(c1_ed[d]);
      end
    end
  end

  // Range check and magnitude for the wrap modulo.
  logic [NUM_DIMS-1:0]               neg_v, pad_v;
  logic [NUM_DIMS-1:0][CW-1:0]       negc;
  logic [NUM_DIMS-1:0][MW-1:0]       mag;
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] clow;

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      neg_v[d] = c2_c[d][CW-1];
      negc[d]  = -c2_c[d];
      mag[d]   = neg_v[d] ? negc[d][MW-1:0] : c2_c[d][MW-1:0];
      pad_v[d] = neg_v[d] || (c2_c[d][MW-1:0] >= MW'(sz[d]));
      clow[d]  = c2_c[d][DIM_BITS-1:0];
    end
  end

  // Modulo of every coordinate magnitude by its array size.
  logic                              mo_valid;
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] mo_rem;
  logic [MSIDE-1:0]                  mo_side;
  logic                              mo_bad;
  logic [NUM_DIMS-1:0]               mo_neg, mo_pad;
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] mo_clow;

  ndwag_divider #(
    .LANES (NUM_DIMS),
    .NUM_W (MW),
    .DEN_W (DIM_BITS),
    .SIDE_W(MSIDE)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (c2_valid),
    .in_num   (mag),
    .den      (sz),
    .in_side  ({c2_bad, neg_v, pad_v, clow}),
    .out_valid(mo_valid),
    .out_quo  (),
    .out_rem  (mo_rem),
    .out_side (mo_side)
  );

  assign {mo_bad, mo_neg, mo_pad, mo_clow} = mo_side;

  // Stage F0: final coordinate per dimension and the padding flag.
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] cu_next;
  logic [NUM_DIMS-1:0]               padd;

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      padd[d] = used[d] && !wrap_mask[d] && mo_pad[d];
      if (!used[d]) begin
        cu_next[d] = '0;
      end else if (wrap_mask[d]) begin
        if (sz[d] == '0) begin
          cu_next[d] = '0;
        end else if (mo_neg[d] && mo_rem[d] != '0) begin
          cu_next[d] = sz[d] - mo_rem[d];
        end else begin
          cu_next[d] = mo_rem[d];
        end
      end else begin
        cu_next[d] = mo_pad[d] ? '0 : mo_clow[d];
      end
    end
  end

  logic                              f0_valid, f0_pad, f0_bad;
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] f0_cu;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
    end else if (adv) begin
      f0_valid <= mo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_cu  <= cu_next;
      f0_pad <= |padd;
      f0_bad <= mo_bad;
    end
  end

  // Stage F1: scale each coordinate by its row-major weight.
  logic                               f1_valid, f1_pad, f1_bad;
  logic [NUM_DIMS-1:0][ADDR_BITS-1:0] f1_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= f0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_pad <= f0_pad;
      f1_bad <= f0_bad;
      for (int d = 0; d < NUM_DIMS; d++) begin
        f1_term[d] <= ADDR_BITS'(f0_cu[d]) * mscale[d];
      end
    end
  end

  // Output stage: sum the terms; padding and bad elements give address zero.
  logic [ADDR_BITS-1:0] addr_sum;
  logic [OUT_W-1:0]     sum_trim;

  always_comb begin
    addr_sum = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      addr_sum = addr_sum + f1_term[d];
    end
  end

  if (ADDR_BITS >= OUT_W) begin : g_trim
    assign sum_trim = addr_sum[OUT_W-1:0];
  end else begin : g_ext
    assign sum_trim = {(OUT_W-ADDR_BITS)'(0), addr_sum};
  end

  logic [OUT_W-1:0] out_addr;
  logic             out_pad, out_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_addr <= (f1_pad || f1_bad) ? '0 : sum_trim;
      out_pad  <= f1_pad && !f1_bad;
      out_bad  <= f1_bad;
    end
  end

  assign m_tdata = {(OUT_TD_W-OUT_W-2)'(0), out_bad, out_pad, out_addr};

endmodule
